@@ rtl/core/slgf_pkg.sv @@
// Shared types and constants of the subpixel LCD glyph filter.
// No dependencies; taken in by the interfaces, the core and the checker.
package slgf_pkg;

    localparam int WEIGHT_W  = 16;   // Q4.12 tap weight
    localparam int FRAC_BITS = 12;
    localparam int SAT_MAX   = 255;  // output byte ceiling
    localparam int COV_W     = 7;    // coverage field width
    localparam int BYTE_W    = 8;
    localparam int DEPTH     = 4;    // pending bytes after the newest sample
    localparam int RES_DEPTH = 8;    // max results caused by one sample
    localparam int CNT_W     = $clog2(RES_DEPTH + 1);
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [WEIGHT_W-1:0] PRIMARY_RST   = 16'd14283;
    localparam logic [WEIGHT_W-1:0] SECONDARY_RST = 16'd1428;
    localparam logic [WEIGHT_W-1:0] TERTIARY_RST  = 16'd357;

    typedef enum logic [1:0] {
        REG_PRIMARY   = 2'd0,
        REG_SECONDARY = 2'd1,
        REG_TERTIARY  = 2'd2
    } reg_idx_t;

endpackage

@@ rtl/core/slgf_if.sv @@
// Valid/ready stream interfaces of the glyph filter: samples in, bytes out.
// Depends on slgf_pkg for field widths.
interface slgf_in_if import slgf_pkg::*;;
    logic             valid;
    logic             ready;
    logic [COV_W-1:0] coverage;
    logic             row_end;

    modport source (output valid, output coverage, output row_end, input ready);
    modport sink   (input valid, input coverage, input row_end, output ready);
endinterface

interface slgf_out_if import slgf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] subpixel_value;
    logic              last_of_row;

    modport source (output valid, output subpixel_value, output last_of_row, input ready);
    modport sink   (input valid, input subpixel_value, input last_of_row, output ready);
endinterface

@@ rtl/core/subpixel_lcd_glyph_filter.sv @@
// Subpixel LCD glyph filter: five-tap distribution of coverage samples.
// Depends on slgf_pkg and the stream interfaces in slgf_if.sv.
//
//  channel      dir  handshake       payload
//  sample_in    in   valid/ready     coverage[6:0], row_end
//  result_out   out  valid/ready     subpixel_value[7:0], last_of_row
//  APB          in   psel/penable    weight_primary/secondary/tertiary @ 0x0/0x4/0x8
//
// Flow: one sample per cycle sustained while result_out stays ready. A
// sample is registered with its three tap products in the tap register at
// its transfer; when the queue takes it, it is folded into the pending sums
// and its byte is loaded into the queue that drives result_out. A row-end
// sample queues 5 to 8 bytes; the input stalls while they drain.
// Reset clears the pending sums, the column phase, the queue and the weights
// to their defaults. A stall on result_out holds the queue; one more sample
// waits in the tap register and then sample_in.ready drops.
module subpixel_lcd_glyph_filter import slgf_pkg::*; #(
    parameter int GRAY_LEVELS = 65
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    slgf_in_if.sink            sample_in,
    slgf_out_if.source         result_out
);

    // clamped level width and tap width after the Q4.12 truncation
    localparam int LVL_W  = $clog2(GRAY_LEVELS);
    localparam int PROD_W = LVL_W + WEIGHT_W;
    localparam int TAP_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = ((TAP_W > BYTE_W) ? TAP_W : BYTE_W) + 1;

    function automatic logic [BYTE_W-1:0] sat_add(
        input logic [BYTE_W-1:0] a,
        input logic [TAP_W-1:0]  b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        return (s > SUM_W'(SAT_MAX)) ? BYTE_W'(SAT_MAX) : s[BYTE_W-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [WEIGHT_W-1:0] wt_p_reg, wt_s_reg, wt_t_reg;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_p_reg <= PRIMARY_RST;
            wt_s_reg <= SECONDARY_RST;
            wt_t_reg <= TERTIARY_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_PRIMARY:   wt_p_reg <= pwdata[WEIGHT_W-1:0];
                REG_SECONDARY: wt_s_reg <= pwdata[WEIGHT_W-1:0];
                REG_TERTIARY:  wt_t_reg <= pwdata[WEIGHT_W-1:0];
                default: ;     // unmapped slot, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PRIMARY:   prdata = PDATA_W'(wt_p_reg);
            REG_SECONDARY: prdata = PDATA_W'(wt_s_reg);
            REG_TERTIARY:  prdata = PDATA_W'(wt_t_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- stage 1: clamp and tap products ----------------
    logic [LVL_W-1:0]  lvl;
    logic [PROD_W-1:0] prod_p, prod_s, prod_t;
    logic              in_xfer, in_ready;

    always_comb
    begin
        if (32'(sample_in.coverage) > GRAY_LEVELS - 1)
            lvl = LVL_W'(GRAY_LEVELS - 1);
        else
            lvl = LVL_W'(sample_in.coverage);
    end

    assign prod_p = PROD_W'(lvl) * PROD_W'(wt_p_reg);
    assign prod_s = PROD_W'(lvl) * PROD_W'(wt_s_reg);
    assign prod_t = PROD_W'(lvl) * PROD_W'(wt_t_reg);

    assign sample_in.ready = in_ready;
    assign in_xfer         = sample_in.valid && in_ready;

    logic             tap_vld_reg;
    logic             tap_end_reg;
    logic [TAP_W-1:0] tap_p_reg, tap_s_reg, tap_t_reg;

    // ---------------- stage 2: accumulate, queue results ----------------
    logic [BYTE_W-1:0] pend_reg [DEPTH];
    logic [BYTE_W-1:0] pend_upd [DEPTH];
    logic [1:0]        phase_reg;
    logic [1:0]        pad;
    logic [BYTE_W-1:0] done;

    logic [BYTE_W-1:0] q_val_reg [RES_DEPTH];
    logic [BYTE_W-1:0] q_val_next [RES_DEPTH];
    logic [CNT_W-1:0]  q_cnt_reg, q_cnt_next;
    logic              q_end_reg;
    logic              out_xfer, fire;

    assign done        = sat_add(pend_reg[0], tap_t_reg);
    assign pend_upd[0] = sat_add(pend_reg[1], tap_s_reg);
    assign pend_upd[1] = sat_add(pend_reg[2], tap_p_reg);
    assign pend_upd[2] = sat_add(pend_reg[3], tap_s_reg);
    assign pend_upd[3] = sat_add('0, tap_t_reg);

    // zero bytes that round the row up to a multiple of four
    assign pad = 2'd0 - (phase_reg + 2'd1);

    assign out_xfer = result_out.valid && result_out.ready;
    // queue takes a new batch when empty or when its last byte leaves now
    assign fire     = tap_vld_reg &&
                      ((q_cnt_reg == '0) || ((q_cnt_reg == CNT_W'(1)) && out_xfer));
    assign in_ready = !tap_vld_reg || fire;

    always_comb
    begin
        q_val_next = q_val_reg;
        q_cnt_next = q_cnt_reg;
        if (fire)
        begin
            for (int i = 0; i < RES_DEPTH; i++)
                q_val_next[i] = '0;
            q_val_next[0] = done;
            if (tap_end_reg)
            begin
                for (int i = 0; i < DEPTH; i++)
                    q_val_next[i+1] = pend_upd[i];
                q_cnt_next = CNT_W'(DEPTH + 1) + CNT_W'(pad);
            end
            else
                q_cnt_next = CNT_W'(1);
        end
        else if (out_xfer)
        begin
            for (int i = 0; i < RES_DEPTH - 1; i++)
                q_val_next[i] = q_val_reg[i+1];
            q_val_next[RES_DEPTH-1] = '0;
            q_cnt_next = q_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_vld_reg <= 1'b0;
            phase_reg   <= '0;
            q_cnt_reg   <= '0;
            q_end_reg   <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
                pend_reg[i] <= '0;
        end
        else
        begin
            if (in_ready)
                tap_vld_reg <= in_xfer;
            q_cnt_reg <= q_cnt_next;
            if (fire)
            begin
                q_end_reg <= tap_end_reg;
                if (tap_end_reg)
                begin
                    phase_reg <= '0;
                    for (int i = 0; i < DEPTH; i++)
                        pend_reg[i] <= '0;
                end
                else
                begin
                    phase_reg <= phase_reg + 2'd1;
                    pend_reg  <= pend_upd;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tap_p_reg   <= prod_p[PROD_W-1:FRAC_BITS];
            tap_s_reg   <= prod_s[PROD_W-1:FRAC_BITS];
            tap_t_reg   <= prod_t[PROD_W-1:FRAC_BITS];
            tap_end_reg <= sample_in.row_end;
        end
        q_val_reg <= q_val_next;
    end

    assign result_out.valid          = (q_cnt_reg != '0);
    assign result_out.subpixel_value = q_val_reg[0];
    assign result_out.last_of_row    = q_end_reg && (q_cnt_reg == CNT_W'(1));

endmodule

@@ rtl/core/slgf_checker.sv @@
// Port-level checks of the glyph filter, bound to the top level.
// Depends on slgf_pkg and subpixel_lcd_glyph_filter.
module slgf_checker import slgf_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_value,
    input logic              out_last
);

    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    // input only backs up behind pending output
    a_ready_low_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("sample_in stalled with no result pending");

    // nothing appears on the output without a recent input transfer
    a_no_spurious_output: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !$past(in_xfer) && !in_xfer) |=> !out_valid)
        else $error("result appeared without a sample in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_value) && $stable(out_last)))
        else $error("stalled result changed");

endmodule

bind subpixel_lcd_glyph_filter slgf_checker u_slgf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_value (result_out.subpixel_value),
    .out_last  (result_out.last_of_row)
);

@@ dv/subpixel_lcd_glyph_filter_tb.sv @@
// Self-checking testbench for the subpixel LCD glyph filter.
// Uses slgf_pkg, the stream interfaces in slgf_if.sv and the filter RTL.
`timescale 1ns / 100ps

module subpixel_lcd_glyph_filter_tb;
    import slgf_pkg::*;

    localparam int GRAY_LEVELS    = 65;
    localparam int QUIET_LIMIT    = 5000;  // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES  = 16;    // tail wait before the verdict
    localparam int RANDOM_PER_SET = 70;    // random samples per idling setting

    // Address past the last weight register; writes there must be dropped.
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 4'hC;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } out_byte_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WEIGHTS
    } row_kind_t;

    // One line of the directed sequence: either a sample (optionally with its
    // own byte typed in) or a new set of weights applied while idle.
    typedef struct packed {
        row_kind_t         kind;
        logic [COV_W-1:0]  coverage;
        logic              row_last;
        logic              typed;
        logic [BYTE_W-1:0] value;
        logic [WEIGHT_W-1:0] wp;
        logic [WEIGHT_W-1:0] ws;
        logic [WEIGHT_W-1:0] wt;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    slgf_in_if  sample_if ();
    slgf_out_if result_if ();

    subpixel_lcd_glyph_filter #(
        .GRAY_LEVELS (GRAY_LEVELS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sample_in  (sample_if),
        .result_out (result_if)
    );

    // Shadow of the weight registers and of the filter's running state.
    logic [WEIGHT_W-1:0] weight_regs [3];
    logic [BYTE_W-1:0]   tail_sums [DEPTH];
    logic [1:0]          col_phase;

    out_byte_t expected_bytes [$];  // bytes still owed by the filter, oldest first

    // Typed-in first byte of the sample currently being offered.
    logic      typed_first_en;
    out_byte_t typed_first;

    int mismatch_count;
    int quiet_cycles;
    int idle_pct;    // chance per cycle that the sample side holds off
    int stall_pct;   // chance per cycle that the byte side is not ready

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Filter predictor
    // ------------------------------------------------------------------

    // Q4.12 tap: 7-bit level times 16-bit weight, fraction truncated.
    function automatic logic [10:0] tap_of(logic [COV_W-1:0] level,
                                           logic [WEIGHT_W-1:0] weight);
        logic [22:0] prod;
        prod = level * weight;
        return prod[22:12];
    endfunction

    function automatic logic [BYTE_W-1:0] sat_add(logic [BYTE_W-1:0] a, logic [10:0] b);
        logic [11:0] sum;
        sum = {4'b0, a} + b;
        return (sum > SAT_MAX) ? BYTE_W'(SAT_MAX) : sum[BYTE_W-1:0];
    endfunction

    // Spread one sample over five bytes T S P S T and queue every byte it
    // finishes. A row end also flushes the four pending bytes and pads the
    // row out to a multiple of four, plus four.
    function automatic void spread_sample(logic [COV_W-1:0] coverage, logic row_last);
        logic [COV_W-1:0] level;
        logic [10:0]      tp;
        logic [10:0]      ts;
        logic [10:0]      tt;
        logic [1:0]       pad;
        level = (coverage > COV_W'(GRAY_LEVELS - 1)) ? COV_W'(GRAY_LEVELS - 1) : coverage;
        tp = tap_of(level, weight_regs[REG_PRIMARY]);
        ts = tap_of(level, weight_regs[REG_SECONDARY]);
        tt = tap_of(level, weight_regs[REG_TERTIARY]);

        expected_bytes.push_back(out_byte_t'{sat_add(tail_sums[0], tt), 1'b0});
        tail_sums[0] = sat_add(tail_sums[1], ts);
        tail_sums[1] = sat_add(tail_sums[2], tp);
        tail_sums[2] = sat_add(tail_sums[3], ts);
        tail_sums[3] = sat_add(8'd0, tt);

        if (!row_last)
        begin
            col_phase = col_phase + 2'd1;
            return;
        end

        // phase counts samples of the row mod 4, minus the one just taken
        pad = 2'd3 - col_phase;
        for (int i = 0; i < DEPTH; i++)
        begin
            expected_bytes.push_back(out_byte_t'{tail_sums[i],
                                                 (pad == 2'd0) && (i == DEPTH - 1)});
            tail_sums[i] = '0;
        end
        for (int i = 0; i < pad; i++)
            expected_bytes.push_back(out_byte_t'{8'd0, i == pad - 1});
        col_phase = '0;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on each sample transfer, checks each byte transfer.
    // Both in one process so a prediction always lands before its bytes.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : byte_check
        int unsigned first_idx;
        out_byte_t   want;
        if (rst_n)
        begin
            if (sample_if.valid && sample_if.ready)
            begin
                first_idx = expected_bytes.size();
                spread_sample(sample_if.coverage, sample_if.row_end);
                if (typed_first_en)
                    expected_bytes[first_idx] = typed_first;
            end
            if (result_if.valid && result_if.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected byte: subpixel_value %0d last_of_row %0b",
                           result_if.subpixel_value, result_if.last_of_row);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (result_if.subpixel_value !== want.value)
                    begin
                        $error("subpixel_value: expected %0d, actual %0d",
                               want.value, result_if.subpixel_value);
                        mismatch_count++;
                    end
                    if (result_if.last_of_row !== want.last)
                    begin
                        $error("last_of_row: expected %0b, actual %0b",
                               want.last, result_if.last_of_row);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: any transfer on either stream restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_if.valid && sample_if.ready)
                   || (result_if.valid && result_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Byte side backpressure.
    always @(negedge clk)
        result_if.ready <= ($urandom_range(99) >= stall_pct);

    // ------------------------------------------------------------------
    // APB and stream drivers; everything changes on the falling edge.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read back every weight register against the shadow copy.
    task automatic check_weights();
        logic [PDATA_W-1:0] rd;
        foreach (weight_regs[i])
        begin
            apb_read(PADDR_W'(4 * i), rd);
            if (rd !== PDATA_W'(weight_regs[i]))
            begin
                $error("weight register %0d: expected %0d, actual %0d",
                       i, weight_regs[i], rd);
                mismatch_count++;
            end
        end
    endtask

    // Only called with the filter drained.
    task automatic set_weights(input logic [WEIGHT_W-1:0] wp, input logic [WEIGHT_W-1:0] ws,
                               input logic [WEIGHT_W-1:0] wt);
        apb_write(PADDR_W'({REG_PRIMARY, 2'b00}), PDATA_W'(wp));
        weight_regs[REG_PRIMARY] = wp;
        apb_write(PADDR_W'({REG_SECONDARY, 2'b00}), PDATA_W'(ws));
        weight_regs[REG_SECONDARY] = ws;
        apb_write(PADDR_W'({REG_TERTIARY, 2'b00}), PDATA_W'(wt));
        weight_regs[REG_TERTIARY] = wt;
        check_weights();
    endtask

    // Offer one sample, with random hold-off, and wait for its transfer.
    task automatic drive_sample(input logic [COV_W-1:0] coverage, input logic row_last,
                                input logic typed, input logic [BYTE_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(negedge clk);
        end
        typed_first_en = typed;
        typed_first    = out_byte_t'{value, 1'b0};
        sample_if.valid    <= 1'b1;
        sample_if.coverage <= coverage;
        sample_if.row_end  <= row_last;
        do @(posedge clk); while (!sample_if.ready);
    endtask

    // Drop valid and wait until every owed byte has come out.
    task automatic wait_drained();
        @(negedge clk);
        sample_if.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic stim_row_t sample_row(int coverage, bit row_last);
        stim_row_t r;
        r          = '0;
        r.kind     = ROW_SAMPLE;
        r.coverage = COV_W'(coverage);
        r.row_last = row_last;
        return r;
    endfunction

    function automatic stim_row_t typed_row(int coverage, bit row_last, int value);
        stim_row_t r;
        r       = sample_row(coverage, row_last);
        r.typed = 1'b1;
        r.value = BYTE_W'(value);
        return r;
    endfunction

    function automatic stim_row_t weight_row(int wp, int ws, int wt);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_WEIGHTS;
        r.wp   = WEIGHT_W'(wp);
        r.ws   = WEIGHT_W'(ws);
        r.wt   = WEIGHT_W'(wt);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t directed [$];
        int        pick;
        logic [COV_W-1:0] coverage;
        logic      row_last;

        clk                = 1'b0;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sample_if.valid    = 1'b0;
        sample_if.coverage = '0;
        sample_if.row_end  = 1'b0;
        result_if.ready    = 1'b0;
        typed_first_en     = 1'b0;
        typed_first        = '0;
        mismatch_count     = 0;
        quiet_cycles       = 0;
        idle_pct           = 30;
        stall_pct          = 87;
        weight_regs[REG_PRIMARY]   = PRIMARY_RST;
        weight_regs[REG_SECONDARY] = SECONDARY_RST;
        weight_regs[REG_TERTIARY]  = TERTIARY_RST;
        foreach (tail_sums[i])
            tail_sums[i] = '0;
        col_phase = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Weights must come out of reset at their defaults.
        check_weights();

        // Rows of length 1 to 4 reach every padding count (3, 0, 2, 1).
        // Coverage above the gray range clamps; 127 sets every input bit.
        directed = '{
            typed_row(0, 0, 0),            // silent sample right after reset
            sample_row(64, 0),
            sample_row(64, 0),
            sample_row(65, 0),             // just above range
            sample_row(127, 1),            // all bits set, ends a 5-sample row
            sample_row(32, 1),             // one-sample row
            sample_row(1, 0),
            sample_row(2, 0),
            sample_row(4, 0),
            sample_row(8, 1),              // row of four: no padding
            sample_row(16, 0),
            sample_row(63, 1),
            sample_row(64, 0),
            sample_row(0, 0),
            sample_row(64, 1),
            weight_row(16'hFFFF, 16'hFFFF, 16'hFFFF),
            typed_row(64, 0, 255),         // every tap saturates
            typed_row(1, 0, 255),          // carried secondary tap already at ceiling
            sample_row(0, 1),
            weight_row(0, 0, 0),
            typed_row(64, 0, 0),
            typed_row(127, 1, 0)
        };

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_WEIGHTS)
            begin
                wait_drained();
                set_weights(directed[i].wp, directed[i].ws, directed[i].wt);
            end
            else
                drive_sample(directed[i].coverage, directed[i].row_last,
                             directed[i].typed, directed[i].value);
        end
        wait_drained();

        // A write past the last register must leave all weights untouched.
        apb_write(ADDR_UNMAPPED, $urandom);
        check_weights();

        // Random part: three idling settings, each with its own weights.
        for (int set = 0; set < 3; set++)
        begin
            case (set)
                0:
                begin
                    idle_pct  = 30;
                    stall_pct = 87;
                    set_weights(PRIMARY_RST, SECONDARY_RST, TERTIARY_RST);
                end
                1:
                begin
                    idle_pct  = 87;
                    stall_pct = 30;
                    set_weights(WEIGHT_W'($urandom_range(20000, 4000)),
                                WEIGHT_W'($urandom_range(4000, 0)),
                                WEIGHT_W'($urandom_range(1500, 0)));
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    set_weights(WEIGHT_W'($urandom_range(65535, 0)),
                                WEIGHT_W'($urandom_range(65535, 0)),
                                WEIGHT_W'($urandom_range(65535, 0)));
                end
            endcase

            for (int n = 0; n < RANDOM_PER_SET; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    coverage = '0;
                else if (pick < 18)
                    coverage = COV_W'(GRAY_LEVELS - 1);
                else if (pick < 28)
                    coverage = COV_W'($urandom_range(127, GRAY_LEVELS));
                else
                    coverage = COV_W'($urandom_range(GRAY_LEVELS - 1, 0));
                row_last = ($urandom_range(5) == 0);
                // close the final row so its tail bytes are checked too
                if (set == 2 && n == RANDOM_PER_SET - 1)
                    row_last = 1'b1;
                drive_sample(coverage, row_last, 1'b0, '0);
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
